@@ rtl/tcch_pkg.sv @@
// Shared constants, types and helper functions of the tilt-compensated compass.
package tcch_pkg;

    // Sample field widths
    localparam int DW   = 16;
    localparam int MW   = DW + 1;
    localparam int PW   = 15;

    // CORDIC iteration count, capped at the table length
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    // Datapath widths
    localparam int VW   = 56;           // vectoring x/y
    localparam int AW   = 26;           // angle, Q16 degrees
    localparam int RW   = 34;           // rotation x/y internal
    localparam int SCW  = 32;           // sin/cos Q30
    localparam int TW   = 2 * SCW - 30; // Q30 product after shift by 30
    localparam int HW   = 53;           // horizontal field
    localparam int SQW  = 48;           // square sum radicand
    localparam int RTW  = SQW / 2;      // root
    localparam int REMW = RTW + 3;      // root remainder

    // Pipeline bookkeeping
    localparam int CORDIC_LAT = NS + 2;
    localparam int ACC_DLY    = 2 + RTW;
    localparam int MAG_DLY    = ACC_DLY + 2 * CORDIC_LAT;
    localparam int ANG_DLY    = 2 * CORDIC_LAT + 3;
    localparam int PIPE_LEN   = 3 + RTW + 3 * CORDIC_LAT + 4;

    // Angle constants
    localparam logic signed [AW-1:0] DEG180 = AW'(180 * 65536);
    localparam logic signed [AW-1:0] DEG90  = AW'(90 * 65536);
    localparam logic signed [RW-1:0] KINV   = RW'(652032874);
    localparam logic signed [AW:0]   RND_HALF  = (AW+1)'(256);
    localparam logic signed [AW:0]   LIM_180   = (AW+1)'(23040);
    localparam logic signed [AW:0]   LIM_90    = (AW+1)'(11520);
    localparam logic signed [AW:0]   FULL_TURN = (AW+1)'(46080);

    // Configuration port
    localparam int AWID = 4;
    localparam int PDW  = 32;

    typedef enum logic [1:0] {
        REG_MAG_OFFSET_X = 2'd0,
        REG_MAG_OFFSET_Y = 2'd1,
        REG_MAG_OFFSET_Z = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [DW-1:0] ax;
        logic signed [DW-1:0] ay;
        logic signed [DW-1:0] az;
    } accel_t;

    typedef struct packed {
        logic signed [MW-1:0] mx;
        logic signed [MW-1:0] my;
        logic signed [MW-1:0] mz;
    } mag_t;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
    } angle_t;

    // atan(2^-i) in Q16 degrees
    function automatic logic signed [AW-1:0] atan_q16(input int i);
        case (i)
            0:  atan_q16 = AW'(2949120);
            1:  atan_q16 = AW'(1740967);
            2:  atan_q16 = AW'(919879);
            3:  atan_q16 = AW'(466945);
            4:  atan_q16 = AW'(234379);
            5:  atan_q16 = AW'(117304);
            6:  atan_q16 = AW'(58666);
            7:  atan_q16 = AW'(29335);
            8:  atan_q16 = AW'(14668);
            9:  atan_q16 = AW'(7334);
            10: atan_q16 = AW'(3667);
            11: atan_q16 = AW'(1833);
            12: atan_q16 = AW'(917);
            13: atan_q16 = AW'(458);
            14: atan_q16 = AW'(229);
            15: atan_q16 = AW'(115);
            16: atan_q16 = AW'(57);
            17: atan_q16 = AW'(29);
            18: atan_q16 = AW'(14);
            19: atan_q16 = AW'(7);
            20: atan_q16 = AW'(4);
            21: atan_q16 = AW'(2);
            22: atan_q16 = AW'(1);
            default: atan_q16 = '0;
        endcase
    endfunction

    // Round Q16 degrees to 1/128 degree and clamp to +-lim
    function automatic logic signed [AW:0] to_out(input logic signed [AW-1:0] z,
                                                 input logic signed [AW:0] lim);
        logic signed [AW:0] s;
        logic signed [AW:0] r;
        s = (AW+1)'(z) + RND_HALF;
        r = s >>> 9;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        to_out = r;
    endfunction

endpackage

@@ rtl/tcch_ifs.sv @@
// Stream interfaces for sensor words and result words.
interface tcch_sensor_if;
    import tcch_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] accel_x;
    logic signed [DW-1:0] accel_y;
    logic signed [DW-1:0] accel_z;
    logic signed [DW-1:0] mag_x;
    logic signed [DW-1:0] mag_y;
    logic signed [DW-1:0] mag_z;

    modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                    output ready);
endinterface

interface tcch_result_if;
    import tcch_pkg::*;
    logic                 valid;
    logic                 ready;
    logic        [DW-1:0] heading_deg;
    logic signed [PW-1:0] pitch_deg;
    logic signed [DW-1:0] roll_deg;

    modport source (output valid, heading_deg, pitch_deg, roll_deg, input ready);
    modport sink   (input valid, heading_deg, pitch_deg, roll_deg, output ready);
endinterface

@@ rtl/tilt_compensated_compass_heading_top.sv @@
// Throughput: one word per cycle unless stalled; all stage registers advance together.
// A stalled result word holds the whole pipeline until it is taken.
// Reset clears the valid bits of every stage and the hard-iron offset registers.
// Top level: square-root pipeline, three CORDIC passes, field rotation and rounding.
module tilt_compensated_compass_heading_top (
    input  logic                        clk,
    input  logic                        rst_n,
    tcch_sensor_if.sink                 sensor,
    tcch_result_if.source               result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcch_pkg::AWID-1:0]   paddr,
    input  logic [tcch_pkg::PDW-1:0]    pwdata,
    output logic [tcch_pkg::PDW-1:0]    prdata,
    output logic                        pready
);
    import tcch_pkg::*;

    logic                 en;
    logic                 v_reg [0:PIPE_LEN-1];
    logic signed [DW-1:0] off_x_reg;
    logic signed [DW-1:0] off_y_reg;
    logic signed [DW-1:0] off_z_reg;
    reg_idx_t             widx;
    reg_idx_t             ridx;

    // Stage A/B
    accel_t               acc_a_reg;
    mag_t                 mag_a_reg;
    logic        [30:0]   sqx_reg;
    logic        [30:0]   sqz_reg;
    logic signed [2*DW-1:0] sqx_full;
    logic signed [2*DW-1:0] sqz_full;

    // Square root
    logic [SQW-1:0]  n_reg    [0:RTW];
    logic [REMW-1:0] rem_reg  [0:RTW];
    logic [RTW-1:0]  root_reg [0:RTW];
    logic [REMW-1:0] sq_cur   [0:RTW-1];
    logic [REMW-1:0] sq_try   [0:RTW-1];

    // Side delays
    accel_t acc_d [0:ACC_DLY-1];
    mag_t   mag_d [0:MAG_DLY-1];
    angle_t ang_d [0:ANG_DLY-1];

    // CORDIC connections
    logic signed [VW-1:0]  roll_x;
    logic signed [VW-1:0]  roll_y;
    logic signed [VW-1:0]  pitch_x;
    logic signed [VW-1:0]  pitch_y;
    logic signed [AW-1:0]  roll_z;
    logic signed [AW-1:0]  pitch_z;
    logic signed [SCW-1:0] sr;
    logic signed [SCW-1:0] cr;
    logic signed [SCW-1:0] sp;
    logic signed [SCW-1:0] cp;

    // Field rotation
    logic signed [2*SCW-1:0] srsp_reg;
    logic signed [2*SCW-1:0] srcp_reg;
    logic signed [MW+SCW-1:0] mxcp_reg;
    logic signed [MW+SCW-1:0] mzsp_reg;
    logic signed [MW+SCW-1:0] mycr_reg;
    logic signed [MW+SCW-1:0] mycr2_reg;
    logic signed [MW-1:0]     mx1_reg;
    logic signed [MW-1:0]     mz1_reg;
    logic signed [MW+TW-1:0]  mxt1_reg;
    logic signed [MW+TW-1:0]  mzt2_reg;
    logic signed [HW-1:0]     hx2_reg;
    logic signed [HW-1:0]     hx_reg;
    logic signed [HW-1:0]     hy_reg;
    logic signed [TW-1:0]     t1;
    logic signed [TW-1:0]     t2;
    logic signed [AW-1:0]     head_z;

    // Output
    logic signed [AW:0]   head_r;
    logic signed [AW:0]   head_w;
    logic signed [AW:0]   pitch_r;
    logic signed [AW:0]   roll_r;
    logic        [DW-1:0] head_reg;
    logic signed [PW-1:0] pitch_reg;
    logic signed [DW-1:0] roll_reg;

    // Advance when the result stage is empty or being taken
    assign en           = !v_reg[PIPE_LEN-1] || result.ready;
    assign sensor.ready = en;

    // Valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LEN; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= sensor.valid;
            for (int i = 1; i < PIPE_LEN; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // Configuration registers
    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[3:2]);
    assign ridx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_MAG_OFFSET_X: off_x_reg <= pwdata[DW-1:0];
                REG_MAG_OFFSET_Y: off_y_reg <= pwdata[DW-1:0];
                REG_MAG_OFFSET_Z: off_z_reg <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_MAG_OFFSET_X: prdata = PDW'(off_x_reg);
            REG_MAG_OFFSET_Y: prdata = PDW'(off_y_reg);
            REG_MAG_OFFSET_Z: prdata = PDW'(off_z_reg);
            default:          prdata = '0;
        endcase
    end

    // Stage A: capture, remove hard-iron offsets with the x/y swap
    // Stage B: squares; stage C: radicand
    assign sqx_full = acc_a_reg.ax * acc_a_reg.ax;
    assign sqz_full = acc_a_reg.az * acc_a_reg.az;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_a_reg.ax <= sensor.accel_x;
            acc_a_reg.ay <= sensor.accel_y;
            acc_a_reg.az <= sensor.accel_z;
            mag_a_reg.my <= MW'(sensor.mag_x) - MW'(off_x_reg);
            mag_a_reg.mx <= MW'(sensor.mag_y) - MW'(off_y_reg);
            mag_a_reg.mz <= MW'(sensor.mag_z) - MW'(off_z_reg);
            sqx_reg      <= sqx_full[30:0];
            sqz_reg      <= sqz_full[30:0];
            n_reg[0]     <= {(32'({1'b0, sqx_reg}) + 32'({1'b0, sqz_reg})), 16'b0};
            rem_reg[0]   <= '0;
            root_reg[0]  <= '0;
        end
    end

    // Square root, one result bit per stage
    always_comb
    begin
        for (int k = 0; k < RTW; k++)
        begin
            sq_cur[k] = {rem_reg[k][REMW-3:0], n_reg[k][SQW-1 -: 2]};
            sq_try[k] = {1'b0, root_reg[k], 2'b01};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RTW; k++)
            begin
                n_reg[k+1] <= n_reg[k] << 2;
                if (sq_cur[k] >= sq_try[k])
                begin
                    rem_reg[k+1]  <= sq_cur[k] - sq_try[k];
                    root_reg[k+1] <= {root_reg[k][RTW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= sq_cur[k];
                    root_reg[k+1] <= {root_reg[k][RTW-2:0], 1'b0};
                end
            end
        end
    end

    // Side delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_d[0] <= acc_a_reg;
            for (int i = 1; i < ACC_DLY; i++)
                acc_d[i] <= acc_d[i-1];
            mag_d[0] <= mag_a_reg;
            for (int i = 1; i < MAG_DLY; i++)
                mag_d[i] <= mag_d[i-1];
            ang_d[0].roll  <= roll_z;
            ang_d[0].pitch <= pitch_z;
            for (int i = 1; i < ANG_DLY; i++)
                ang_d[i] <= ang_d[i-1];
        end
    end

    // Roll and pitch arctangents
    assign roll_x  = VW'(acc_d[ACC_DLY-1].az) <<< 20;
    assign roll_y  = VW'(acc_d[ACC_DLY-1].ax) <<< 20;
    assign pitch_x = VW'({1'b0, root_reg[RTW]}) <<< 12;
    assign pitch_y = -(VW'(acc_d[ACC_DLY-1].ay) <<< 20);

    tcch_cordic_vec u_roll_vec (
        .clk   (clk),
        .en    (en),
        .x_in  (roll_x),
        .y_in  (roll_y),
        .z_out (roll_z)
    );

    tcch_cordic_vec u_pitch_vec (
        .clk   (clk),
        .en    (en),
        .x_in  (pitch_x),
        .y_in  (pitch_y),
        .z_out (pitch_z)
    );

    tcch_cordic_rot u_roll_rot (
        .clk   (clk),
        .en    (en),
        .a_in  (roll_z),
        .s_out (sr),
        .c_out (cr)
    );

    tcch_cordic_rot u_pitch_rot (
        .clk   (clk),
        .en    (en),
        .a_in  (pitch_z),
        .s_out (sp),
        .c_out (cp)
    );

    // Rotate the field into the horizontal plane over three stages
    assign t1 = $signed(srsp_reg[2*SCW-1:30]);
    assign t2 = $signed(srcp_reg[2*SCW-1:30]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp_reg  <= sr * sp;
            srcp_reg  <= sr * cp;
            mxcp_reg  <= mag_d[MAG_DLY-1].mx * cp;
            mzsp_reg  <= mag_d[MAG_DLY-1].mz * sp;
            mycr_reg  <= mag_d[MAG_DLY-1].my * cr;
            mx1_reg   <= mag_d[MAG_DLY-1].mx;
            mz1_reg   <= mag_d[MAG_DLY-1].mz;
            mxt1_reg  <= mx1_reg * t1;
            mzt2_reg  <= mz1_reg * t2;
            hx2_reg   <= HW'(mxcp_reg) + HW'(mzsp_reg);
            mycr2_reg <= mycr_reg;
            hy_reg    <= HW'(mxt1_reg) + HW'(mycr2_reg) - HW'(mzt2_reg);
            hx_reg    <= hx2_reg;
        end
    end

    // Heading arctangent
    tcch_cordic_vec u_head_vec (
        .clk   (clk),
        .en    (en),
        .x_in  (VW'(hx_reg)),
        .y_in  (VW'(hy_reg)),
        .z_out (head_z)
    );

    // Round and clamp all three angles, and wrap the heading into one turn
    always_comb
    begin
        head_r  = to_out(head_z, LIM_180);
        head_w  = (head_r < 0) ? head_r + FULL_TURN : head_r;
        pitch_r = to_out(ang_d[ANG_DLY-1].pitch, LIM_90);
        roll_r  = to_out(ang_d[ANG_DLY-1].roll, LIM_180);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg  <= head_w[DW-1:0];
            pitch_reg <= pitch_r[PW-1:0];
            roll_reg  <= roll_r[DW-1:0];
        end
    end

    assign result.valid       = v_reg[PIPE_LEN-1];
    assign result.heading_deg = head_reg;
    assign result.pitch_deg   = pitch_reg;
    assign result.roll_deg    = roll_reg;

endmodule

@@ rtl/tcch_cordic_vec.sv @@
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q16 degrees.
module tcch_cordic_vec (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [tcch_pkg::VW-1:0] x_in,
    input  logic signed [tcch_pkg::VW-1:0] y_in,
    output logic signed [tcch_pkg::AW-1:0] z_out
);
    import tcch_pkg::*;

    logic signed [VW-1:0] x_reg    [0:NS];
    logic signed [VW-1:0] y_reg    [0:NS];
    logic signed [AW-1:0] z_reg    [0:NS];
    logic                 zero_reg [0:NS];
    logic signed [AW-1:0] zo_reg;

    // Fold the left half plane, then rotate toward the x axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= (y_in >= 0) ? DEG180 : -DEG180;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < NS; i++)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q16(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q16(i);
                end
            end
            // Zero vector gives 0, otherwise saturate to +-180
            if (zero_reg[NS])
                zo_reg <= '0;
            else if (z_reg[NS] > DEG180)
                zo_reg <= DEG180;
            else if (z_reg[NS] < -DEG180)
                zo_reg <= -DEG180;
            else
                zo_reg <= z_reg[NS];
        end
    end

    assign z_out = zo_reg;

endmodule

@@ rtl/tcch_cordic_rot.sv @@
// Pipelined CORDIC rotation unit: sin and cos in Q30 of a Q16-degree angle.
module tcch_cordic_rot (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [tcch_pkg::AW-1:0]  a_in,
    output logic signed [tcch_pkg::SCW-1:0] s_out,
    output logic signed [tcch_pkg::SCW-1:0] c_out
);
    import tcch_pkg::*;

    logic signed [RW-1:0]  x_reg   [0:NS];
    logic signed [RW-1:0]  y_reg   [0:NS];
    logic signed [AW-1:0]  a_reg   [0:NS];
    logic                  neg_reg [0:NS];
    logic signed [SCW-1:0] s_reg;
    logic signed [SCW-1:0] c_reg;

    // Reduce to +-90 degrees, then rotate the prescaled unit vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= KINV;
            y_reg[0] <= '0;
            if (a_in > DEG90)
            begin
                a_reg[0]   <= a_in - DEG180;
                neg_reg[0] <= 1'b1;
            end
            else if (a_in < -DEG90)
            begin
                a_reg[0]   <= a_in + DEG180;
                neg_reg[0] <= 1'b1;
            end
            else
            begin
                a_reg[0]   <= a_in;
                neg_reg[0] <= 1'b0;
            end
            for (int i = 0; i < NS; i++)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (a_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - atan_q16(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + atan_q16(i);
                end
            end
            // Undo the half-turn fold
            s_reg <= SCW'(neg_reg[NS] ? -y_reg[NS] : y_reg[NS]);
            c_reg <= SCW'(neg_reg[NS] ? -x_reg[NS] : x_reg[NS]);
        end
    end

    assign s_out = s_reg;
    assign c_out = c_reg;

endmodule
